// ===== design/ins_pkg.sv =====
package ins_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  ins;
    logic  shift;
    data_t v;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_FILL = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

// ===== design/ins_cell.sv =====
module ins_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  ins_pkg::cell_ctrl_t ctrl,
  input  ins_pkg::data_t     left_value,
  input  logic               left_valid,
  input  logic               left_gt,
  input  ins_pkg::data_t     right_value,
  input  logic               right_valid,
  output ins_pkg::data_t     value,
  output logic               valid,
  output logic               gt
);
  import ins_pkg::*;

  logic take_v;

  assign gt = valid && (value > ctrl.v);

  // empty cell right after the last full one, or first cell above the insertion point
  assign take_v = gt || (!valid && (FIRST || left_valid));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.ins) begin
      if (!FIRST && left_gt) begin
        value <= left_value;
      end else if (take_v) begin
        value <= ctrl.v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.ins) begin
      valid <= valid || FIRST || left_valid;
    end
  end

endmodule

// ===== design/insertion_sorter_top.sv =====
// Streaming stable insertion sorter.
// Slave side (s_*) takes one signed 32-bit value per word; s_tlast marks the
// last value of a set. Each value is placed into a row of CAPACITY cells in
// the accepting cycle: every held entry strictly greater moves up one cell,
// so equal values keep arrival order. Values arriving while all cells are
// full are dropped and the set is flagged.
// After the word with s_tlast is taken, the set is sent on the master side
// (m_*) smallest first, starting the next cycle, one word per cycle while
// m_tready is high; m_tlast marks the final word and m_tuser carries the
// overflow flag on every word of the set. The cell row shifts toward the
// output by one cell per accepted output word.
// Throughput: one input word per cycle while filling; s_tready is low during
// emission, so every held value of a set is sent before the next set may
// start. A stall on m_tready holds the current word and the row.
// Reset empties all cells, clears the overflow flag and returns to filling;
// no clearing pass is needed.
module insertion_sorter_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ins_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
  input  logic                      s_tlast,  // end_of_set
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ins_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
  output logic                      m_tlast,  // final_item
  output logic                      m_tuser   // [0] overflow
);
  import ins_pkg::*;

  state_t     state, state_next;
  logic       dropped;
  cell_ctrl_t ctrl;
  data_t      cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;
  logic       s_fire, m_fire;

  assign s_tready = (state == S_FILL);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (state == S_EMIT) && cell_valid[0];
  assign m_fire   = m_tvalid && m_tready;
  assign m_tdata  = cell_value[0];
  assign m_tlast  = !cell_valid[1];
  assign m_tuser  = dropped;

  assign ctrl.ins   = s_fire && !cell_valid[CAPACITY-1];
  assign ctrl.shift = m_fire;
  assign ctrl.v     = s_tdata;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      data_t l_value, r_value;
      logic  l_valid, l_gt, r_valid;
      if (i == 0) begin : g_first
        assign l_value = '0;
        assign l_valid = 1'b1;
        assign l_gt    = 1'b0;
      end else begin : g_mid
        assign l_value = cell_value[i-1];
        assign l_valid = cell_valid[i-1];
        assign l_gt    = cell_gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign r_value = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_value = cell_value[i+1];
        assign r_valid = cell_valid[i+1];
      end
      ins_cell #(
        .FIRST(i == 0)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .left_value (l_value),
        .left_valid (l_valid),
        .left_gt    (l_gt),
        .right_value(r_value),
        .right_valid(r_valid),
        .value      (cell_value[i]),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (s_fire && s_tlast) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (m_fire && m_tlast) state_next = S_FILL;
      end
      default: state_next = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (m_fire && m_tlast) begin
        dropped <= 1'b0;
      end else if (s_fire && cell_valid[CAPACITY-1]) begin
        dropped <= 1'b1;
      end
    end
  end

  // held entries always fill the row from cell 0 without gaps
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("cell row has a gap");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
    else $error("insert did not add one entry");

  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_tlast) |=> (cell_valid == '0) && !dropped && s_tready)
    else $error("row not empty after final word");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_tlast) |=> !m_tvalid)
    else $error("output before end of set");

endmodule

// ===== tb/insertion_sorter_top_tb.sv =====
module insertion_sorter_top_tb;
  import ins_pkg::*;

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 200;

  typedef struct {
    data_t sorted_value;
    bit    final_item;
    bit    overflow;
  } sorted_word_t;

  class sorted_set_board;
    data_t        set_values[$];
    bit           set_dropped;
    sorted_word_t sorted_due[$];
    int           mismatches;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // stable insert: stop at the first entry not strictly greater
    function void note_word(data_t v, bit last);
      int pos;
      sorted_word_t w;
      if (set_values.size() >= CAP) begin
        set_dropped = 1'b1;
      end else begin
        pos = set_values.size();
        while (pos > 0 && set_values[pos-1] > v) pos--;
        set_values.insert(pos, v);
      end
      if (last) begin
        foreach (set_values[k]) begin
          w.sorted_value = set_values[k];
          w.final_item   = (k == set_values.size() - 1);
          w.overflow     = set_dropped;
          sorted_due.push_back(w);
        end
        set_values.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void check_word(data_t v, bit fin, bit ovf);
      sorted_word_t w;
      if (sorted_due.size() == 0) begin
        flag($sformatf("unexpected word value=%0d last=%0b ovf=%0b", v, fin, ovf));
        return;
      end
      w = sorted_due.pop_front();
      if (w.sorted_value !== v || w.final_item !== fin || w.overflow !== ovf)
        flag($sformatf("exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                       w.sorted_value, w.final_item, w.overflow, v, fin, ovf));
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  sorted_set_board sb;
  int              cycle_count;
  int              words_sent;
  bit              sender_calm;

  insertion_sorter_top #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(data_t'(s_tdata), s_tlast);
      if (m_tvalid && m_tready) sb.check_word(data_t'(m_tdata), m_tlast, m_tuser);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 3))
      0: return data_t'($urandom_range(0, 15)) - 8;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_word(data_t v, bit last);
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
    if (!sender_calm && $urandom_range(0, 99) < 40) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tlast  = 1'($urandom_range(0, 1));
      repeat (idle_len()) @(negedge clk);
    end
  endtask

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_word(rand_value(), i == n - 1);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) < 7) begin
        m_tready = 1'b1;
        repeat ($urandom_range(1, 25)) @(negedge clk);
      end else begin
        m_tready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  initial begin
    int n;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    sender_calm = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-value set, then extremes with a duplicate
    send_word(32'sh7fff_ffff, 1'b1);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(0, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(-1, 1'b1);
    // full store, last word is dropped but still ends the set
    for (int i = 0; i < CAP + 1; i++) send_word(data_t'(CAP - i) * 32'sd1000, i == CAP);

    drain();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1:    n = CAP;
        2:       n = $urandom_range(CAP + 1, CAP + 4);
        3, 4, 5: n = $urandom_range(9, CAP);
        default: n = $urandom_range(1, 8);
      endcase
      send_set(n);
      if ($urandom_range(0, 7) == 0) drain();
    end
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (CAP + 20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0 && !m_tvalid) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ins_pkg.sv
design/ins_cell.sv
design/insertion_sorter_top.sv
tb/insertion_sorter_top_tb.sv
